>>> sv/plcm_pkg.sv
// plcm_pkg: shared types, sizes, status codes and address helper for the
// piecewise linear colormap block; no dependencies
`timescale 1ns / 1ps

package plcm_pkg;

    // map organization
    localparam int MAX_POINTS = 64;
    localparam int NUM_MAPS   = 4;
    localparam int DEPTH      = NUM_MAPS * MAX_POINTS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int MAP_W      = (NUM_MAPS > 1) ? $clog2(NUM_MAPS) : 1;

    // field widths
    localparam int POS_W = 10;
    localparam int CH_W  = 8;
    localparam int PT_W  = POS_W + 3 * CH_W;

    // blend arithmetic widths: channel times span, then doubled plus span
    localparam int NUM_W = CH_W + POS_W;
    localparam int REM_W = NUM_W + 1;
    localparam int STEP_W = $clog2(CH_W);

    // index at or above this returns the last colour
    localparam logic [POS_W-1:0] SCALE_END = POS_W'(1000);

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ORDER = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } rgb_t;

    // one stored control point
    typedef struct packed {
        logic [POS_W-1:0] pos;
        rgb_t             rgb;
    } point_t;

    // request from the sequencer to the blend unit
    typedef struct packed {
        logic             go;
        logic [POS_W-1:0] span;
        logic [POS_W-1:0] delta;
        rgb_t             c0;
        rgb_t             c1;
    } blend_req_t;

    // memory address of point slot idx in map
    function automatic logic [ADDR_W-1:0] pt_addr(input logic [1:0] map,
                                                  input logic [IDX_W-1:0] idx);
        return ADDR_W'(32'(map) * MAX_POINTS + 32'(idx));
    endfunction

endpackage

>>> sv/plcm_point_ram.sv
// plcm_point_ram: control point store, one write and one registered read port
// depends on plcm_pkg
`timescale 1ns / 1ps

module plcm_point_ram
    import plcm_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [PT_W-1:0]   wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [PT_W-1:0]   rdata
);

    logic [PT_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> sv/plcm_blend_div.sv
// plcm_blend_div: per-channel linear blend with round-to-nearest, using one
// shared multiply stage and a restoring divider, one quotient bit per cycle
// depends on plcm_pkg
`timescale 1ns / 1ps

module plcm_blend_div
    import plcm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  blend_req_t req,
    output logic       done,
    output rgb_t       result
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_MUL  = 2'd1;
    localparam logic [1:0] D_PREP = 2'd2;
    localparam logic [1:0] D_STEP = 2'd3;

    localparam logic [1:0] CH_R = 2'd0;
    localparam logic [1:0] CH_G = 2'd1;
    localparam logic [1:0] CH_B = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        ch_reg, ch_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [CH_W-1:0]   q_reg, q_next;
    rgb_t              res_reg, res_next;
    rgb_t              c0_reg, c0_next;
    rgb_t              c1_reg, c1_next;
    logic [POS_W-1:0]  span_reg, span_next;
    logic [POS_W-1:0]  dist_reg, dist_next;

    logic [CH_W-1:0]   a_ch;
    logic [CH_W-1:0]   b_ch;
    logic [REM_W-1:0]  trial;

    // channel select for the multiply stage
    always_comb
    begin
        case (ch_reg)
            CH_R:
            begin
                a_ch = c0_reg.r;
                b_ch = c1_reg.r;
            end
            CH_G:
            begin
                a_ch = c0_reg.g;
                b_ch = c1_reg.g;
            end
            default:
            begin
                a_ch = c0_reg.b;
                b_ch = c1_reg.b;
            end
        endcase
    end

    // shifted divisor for the current quotient bit
    assign trial = REM_W'({span_reg, 1'b0}) << step_reg;

    // sequencer: multiply, form dividend, then one quotient bit per cycle
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        res_next   = res_reg;
        c0_next    = c0_reg;
        c1_next    = c1_reg;
        span_next  = span_reg;
        dist_next  = dist_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.go)
                begin
                    c0_next    = req.c0;
                    c1_next    = req.c1;
                    span_next  = req.span;
                    dist_next  = req.delta;
                    ch_next    = CH_R;
                    state_next = D_MUL;
                end
            end
            D_MUL:
            begin
                num_next   = NUM_W'(a_ch) * NUM_W'(span_reg - dist_reg) +
                             NUM_W'(b_ch) * NUM_W'(dist_reg);
                state_next = D_PREP;
            end
            D_PREP:
            begin
                rem_next   = {num_reg, 1'b0} + REM_W'(span_reg);
                q_next     = '0;
                step_next  = STEP_W'(CH_W - 1);
                state_next = D_STEP;
            end
            D_STEP:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next = rem_reg - trial;
                    q_next   = q_reg | (CH_W'(1) << step_reg);
                end
                if (step_reg == '0)
                begin
                    case (ch_reg)
                        CH_R:    res_next.r = q_next;
                        CH_G:    res_next.g = q_next;
                        default: res_next.b = q_next;
                    endcase
                    if (ch_reg == CH_B)
                    begin
                        done_next  = 1'b1;
                        state_next = D_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = D_MUL;
                    end
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        step_reg <= step_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
        c0_reg   <= c0_next;
        c1_reg   <= c1_next;
        span_reg <= span_next;
        dist_reg <= dist_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> sv/piecewise_linear_colormap.sv
// piecewise_linear_colormap: top level, command sequencer around the point
// store and blend unit; depends on plcm_pkg, plcm_point_ram, plcm_blend_div
`timescale 1ns / 1ps

// Holds four colour maps of up to 64 control points each in one single-port
// read / single-port write memory. An item is taken when start is high and
// busy is low; exactly one result follows, shown for one cycle with done high,
// and the receiver cannot stall it, so sample the outputs whenever done is
// set. busy drops in the cycle that shows the result, so the next item can be
// taken there. A load writes its point directly, or first reads the previous
// point for the order check. A query on an empty map is answered from the
// decode state; one before the first or after the last point reads the first
// and last points and then the edge colour; one inside a segment scans
// up to its segment. The segment search reads one point per cycle through the
// memory read port, and the blend runs the three channels through one
// multiply stage and one restoring divider at one quotient bit per cycle.
module piecewise_linear_colormap
    import plcm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             opcode,
    input  logic [1:0]       map_select,
    input  logic             start_map,
    input  logic             reverse_order,
    input  logic [POS_W-1:0] position,
    input  logic [CH_W-1:0]  red_in,
    input  logic [CH_W-1:0]  green_in,
    input  logic [CH_W-1:0]  blue_in,
    output logic             done,
    output logic [CH_W-1:0]  out_red,
    output logic [CH_W-1:0]  out_green,
    output logic [CH_W-1:0]  out_blue,
    output logic [1:0]       status
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_LCMP   = 4'd2;
    localparam logic [3:0] S_QFIRST = 4'd3;
    localparam logic [3:0] S_QLAST  = 4'd4;
    localparam logic [3:0] S_QEDGE  = 4'd5;
    localparam logic [3:0] S_QSCAN  = 4'd6;
    localparam logic [3:0] S_QC0    = 4'd7;
    localparam logic [3:0] S_QC1    = 4'd8;
    localparam logic [3:0] S_QDIV   = 4'd9;

    logic [3:0]       state_reg, state_next;

    // captured command
    logic             op_reg, op_next;
    logic [1:0]       map_reg, map_next;
    logic             stm_reg, stm_next;
    logic             revin_reg, revin_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    rgb_t             rgbin_reg, rgbin_next;

    // per-map state
    logic [CNT_W-1:0] count_reg [NUM_MAPS];
    logic             rev_reg [NUM_MAPS];
    logic             cnt_we;
    logic [CNT_W-1:0] cnt_wval;
    logic             rev_we;

    // query working registers
    logic [CNT_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [POS_W-1:0] prev_reg, prev_next;
    logic [POS_W-1:0] span_reg, span_next;
    logic [POS_W-1:0] dist_reg, dist_next;
    rgb_t             c0_reg, c0_next;

    // result registers
    logic             done_reg, done_next;
    rgb_t             res_rgb_reg, res_rgb_next;
    logic [1:0]       res_st_reg, res_st_next;

    // memory and blend unit interfaces
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    point_t            mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [PT_W-1:0]   mem_rdata;
    point_t            rpt;
    blend_req_t        breq;
    logic              bdone;
    rgb_t              bres;

    logic              map_ok;
    logic [MAP_W-1:0]  mi;
    logic [CNT_W-1:0]  n;
    logic              rev;

    assign map_ok = (32'(map_reg) < NUM_MAPS);
    assign mi     = MAP_W'(map_reg);
    assign n      = count_reg[mi];
    assign rev    = rev_reg[mi];
    assign rpt    = point_t'(mem_rdata);

    // physical slot holding the colour paired with position slot k
    function automatic logic [IDX_W-1:0] colour_idx(input logic [IDX_W-1:0] k,
                                                    input logic [CNT_W-1:0] cnt,
                                                    input logic rv);
        logic [CNT_W-1:0] mirrored;
        mirrored = cnt - CNT_W'(1) - CNT_W'(k);
        return rv ? IDX_W'(mirrored) : k;
    endfunction

    plcm_point_ram u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    plcm_blend_div u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (breq),
        .done   (bdone),
        .result (bres)
    );

    // command sequencer; one item at a time, so no store access overlaps
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        map_next     = map_reg;
        stm_next     = stm_reg;
        revin_next   = revin_reg;
        pos_next     = pos_reg;
        rgbin_next   = rgbin_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        prev_next    = prev_reg;
        span_next    = span_reg;
        dist_next    = dist_reg;
        c0_next      = c0_reg;
        done_next    = 1'b0;
        res_rgb_next = res_rgb_reg;
        res_st_next  = res_st_reg;
        cnt_we       = 1'b0;
        cnt_wval     = '0;
        rev_we       = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = pt_addr(map_reg, IDX_W'(n));
        mem_wdata    = '{pos: pos_reg, rgb: rgbin_reg};
        mem_raddr    = '0;
        breq         = '{go: 1'b0, span: span_reg, delta: dist_reg,
                         c0: c0_reg, c1: rpt.rgb};
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = opcode;
                    map_next   = map_select;
                    stm_next   = start_map;
                    revin_next = reverse_order;
                    pos_next   = position;
                    rgbin_next = '{r: red_in, g: green_in, b: blue_in};
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (op_reg == OP_LOAD)
                begin
                    if (!map_ok)
                    begin
                        res_st_next  = ST_OK;
                        res_rgb_next = '0;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else if (stm_reg || (n == '0))
                    begin
                        // first point of the map
                        mem_we       = 1'b1;
                        mem_waddr    = pt_addr(map_reg, '0);
                        cnt_we       = 1'b1;
                        cnt_wval     = CNT_W'(1);
                        rev_we       = stm_reg;
                        res_st_next  = ST_OK;
                        res_rgb_next = '0;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else if (32'(n) >= MAX_POINTS)
                    begin
                        res_st_next  = ST_FULL;
                        res_rgb_next = '0;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        mem_raddr  = pt_addr(map_reg, IDX_W'(n - CNT_W'(1)));
                        state_next = S_LCMP;
                    end
                end
                else
                begin
                    if (!map_ok || (n == '0))
                    begin
                        res_st_next  = ST_EMPTY;
                        res_rgb_next = '0;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        mem_raddr  = pt_addr(map_reg, '0);
                        state_next = S_QFIRST;
                    end
                end
            end
            S_LCMP:
            begin
                // order check against the previous point
                if (pos_reg < rpt.pos)
                begin
                    res_st_next = ST_ORDER;
                end
                else
                begin
                    mem_we      = 1'b1;
                    cnt_we      = 1'b1;
                    cnt_wval    = n + CNT_W'(1);
                    res_st_next = ST_OK;
                end
                res_rgb_next = '0;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            S_QFIRST:
            begin
                prev_next  = rpt.pos;
                mem_raddr  = pt_addr(map_reg, IDX_W'(n - CNT_W'(1)));
                state_next = S_QLAST;
            end
            S_QLAST:
            begin
                if ((pos_reg >= SCALE_END) || (pos_reg >= rpt.pos))
                begin
                    mem_raddr  = pt_addr(map_reg,
                                         colour_idx(IDX_W'(n - CNT_W'(1)), n, rev));
                    state_next = S_QEDGE;
                end
                else if (pos_reg < prev_reg)
                begin
                    mem_raddr  = pt_addr(map_reg, colour_idx('0, n, rev));
                    state_next = S_QEDGE;
                end
                else
                begin
                    j_next     = CNT_W'(1);
                    mem_raddr  = pt_addr(map_reg, IDX_W'(1));
                    state_next = S_QSCAN;
                end
            end
            S_QEDGE:
            begin
                res_st_next  = ST_OK;
                res_rgb_next = rpt.rgb;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end
            S_QSCAN:
            begin
                // rdata holds slot j; on a miss the read of slot j+1 goes out now
                if (rpt.pos > pos_reg)
                begin
                    k_next     = IDX_W'(j_reg - CNT_W'(1));
                    span_next  = rpt.pos - prev_reg;
                    dist_next  = pos_reg - prev_reg;
                    mem_raddr  = pt_addr(map_reg,
                                         colour_idx(IDX_W'(j_reg - CNT_W'(1)), n, rev));
                    state_next = S_QC0;
                end
                else
                begin
                    prev_next = rpt.pos;
                    j_next    = j_reg + CNT_W'(1);
                    mem_raddr = pt_addr(map_reg, IDX_W'(j_reg + CNT_W'(1)));
                end
            end
            S_QC0:
            begin
                c0_next    = rpt.rgb;
                mem_raddr  = pt_addr(map_reg, colour_idx(k_reg + IDX_W'(1), n, rev));
                state_next = S_QC1;
            end
            S_QC1:
            begin
                breq.go    = 1'b1;
                state_next = S_QDIV;
            end
            S_QDIV:
            begin
                if (bdone)
                begin
                    res_st_next  = ST_OK;
                    res_rgb_next = bres;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers and per-map counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_MAPS; i++)
            begin
                count_reg[i] <= '0;
                rev_reg[i]   <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cnt_we)
            begin
                count_reg[mi] <= cnt_wval;
            end
            if (rev_we)
            begin
                rev_reg[mi] <= revin_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        map_reg     <= map_next;
        stm_reg     <= stm_next;
        revin_reg   <= revin_next;
        pos_reg     <= pos_next;
        rgbin_reg   <= rgbin_next;
        j_reg       <= j_next;
        k_reg       <= k_next;
        prev_reg    <= prev_next;
        span_reg    <= span_next;
        dist_reg    <= dist_next;
        c0_reg      <= c0_next;
        res_rgb_reg <= res_rgb_next;
        res_st_reg  <= res_st_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign out_red   = res_rgb_reg.r;
    assign out_green = res_rgb_reg.g;
    assign out_blue  = res_rgb_reg.b;
    assign status    = res_st_reg;

endmodule

>>> sv/plcm_checker.sv
// plcm_checker: port-level checks on the colormap command handshake and results
// depends on plcm_pkg; bound to piecewise_linear_colormap below
`timescale 1ns / 1ps

module plcm_checker
    import plcm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  logic             done,
    input  logic [CH_W-1:0]  out_red,
    input  logic [CH_W-1:0]  out_green,
    input  logic [CH_W-1:0]  out_blue,
    input  logic [1:0]       status
);

    // a transfer in makes the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after input transfer");

    // a result is shown only once the block has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // one item gives one result: no two strobes back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // refused or empty answers carry a zero colour
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |->
            ((out_red == '0) && (out_green == '0) && (out_blue == '0)))
        else $error("nonzero colour with error status");

endmodule

bind piecewise_linear_colormap plcm_checker u_plcm_checker (.*);

>>> tb/tb_piecewise_linear_colormap.sv
// tb_piecewise_linear_colormap: self-checking bench for the colormap block, with a
// cycle-free predictor of the four point maps and their blended lookups
// depends on plcm_pkg and piecewise_linear_colormap
`timescale 1ns / 1ps

module tb_piecewise_linear_colormap;
    import plcm_pkg::*;

    // one command as presented on the input ports
    typedef struct {
        logic             opcode;
        logic [1:0]       map;
        logic             start_map;
        logic             rev;
        logic [POS_W-1:0] pos;
        rgb_t             rgb;
    } cmd_t;

    // one result as seen on the output ports
    typedef struct packed {
        rgb_t       rgb;
        logic [1:0] status;
    } colour_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic             opcode = OP_LOAD;
    logic [1:0]       map_select = '0;
    logic             start_map = 1'b0;
    logic             reverse_order = 1'b0;
    logic [POS_W-1:0] position = '0;
    logic [CH_W-1:0]  red_in = '0;
    logic [CH_W-1:0]  green_in = '0;
    logic [CH_W-1:0]  blue_in = '0;
    logic             done;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic [1:0]       status;

    // predictor copy of the point maps
    logic [POS_W-1:0] map_pos [NUM_MAPS][MAX_POINTS];
    rgb_t             map_rgb [NUM_MAPS][MAX_POINTS];
    int unsigned      map_len [NUM_MAPS];
    bit               map_rev [NUM_MAPS];

    cmd_t           cmds_to_send [$];
    colour_result_t expected_colours [$];
    cmd_t           cur_cmd;
    colour_result_t predicted;
    colour_result_t expected_head;
    int             total_cmds;
    int             sent_count;
    int             mismatches;
    bit             hold_off;

    // coverage tallies for the closing summary
    int n_loads, n_full, n_order, n_queries, n_empty, n_blend;

    piecewise_linear_colormap DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .map_select    (map_select),
        .start_map     (start_map),
        .reverse_order (reverse_order),
        .position      (position),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .done          (done),
        .out_red       (out_red),
        .out_green     (out_green),
        .out_blue      (out_blue),
        .status        (status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // colour paired with position slot k, honoring the reverse bit
    function automatic rgb_t paired_rgb(input int m, input int unsigned k);
        if (map_rev[m])
            return map_rgb[m][map_len[m] - 1 - k];
        return map_rgb[m][k];
    endfunction

    // linear blend of one channel, rounded to nearest with ties up
    function automatic logic [CH_W-1:0] blend_channel(input int unsigned a,
                                                      input int unsigned b,
                                                      input int unsigned span,
                                                      input int unsigned d);
        int unsigned num;
        int unsigned v;
        num = a * (span - d) + b * d;
        v = (2 * num + span) / (2 * span);
        return (v > 255) ? CH_W'(255) : CH_W'(v);
    endfunction

    // advance the map state by one command and give the colour it answers
    task automatic lookup_colour(input cmd_t c, output colour_result_t r);
        int          m;
        int unsigned n;
        int unsigned k;
        int unsigned span;
        int unsigned d;
        rgb_t        e0;
        rgb_t        e1;
        m = c.map;
        r = '0;
        r.status = ST_OK;
        if (c.opcode == OP_LOAD)
        begin
            n_loads++;
            if (c.start_map)
            begin
                map_len[m] = 0;
                map_rev[m] = c.rev;
            end
            n = map_len[m];
            if (n >= MAX_POINTS)
            begin
                r.status = ST_FULL;
                n_full++;
            end
            else if (n > 0 && c.pos < map_pos[m][n - 1])
            begin
                r.status = ST_ORDER;
                n_order++;
            end
            else
            begin
                map_pos[m][n] = c.pos;
                map_rgb[m][n] = c.rgb;
                map_len[m] = n + 1;
            end
        end
        else
        begin
            n_queries++;
            n = map_len[m];
            if (n == 0)
            begin
                r.status = ST_EMPTY;
                n_empty++;
            end
            else if (c.pos >= SCALE_END || c.pos >= map_pos[m][n - 1])
                r.rgb = paired_rgb(m, n - 1);
            else if (c.pos < map_pos[m][0])
                r.rgb = paired_rgb(m, 0);
            else
            begin
                // first segment whose upper end lies beyond the index
                k = 0;
                while (k + 1 < n && map_pos[m][k + 1] <= c.pos)
                    k++;
                span = map_pos[m][k + 1] - map_pos[m][k];
                d = c.pos - map_pos[m][k];
                e0 = paired_rgb(m, k);
                e1 = paired_rgb(m, k + 1);
                r.rgb.r = blend_channel(e0.r, e1.r, span, d);
                r.rgb.g = blend_channel(e0.g, e1.g, span, d);
                r.rgb.b = blend_channel(e0.b, e1.b, span, d);
                n_blend++;
            end
        end
    endtask

    function automatic rgb_t rand_rgb();
        rgb_t c;
        c.r = CH_W'($urandom_range(0, 255));
        c.g = CH_W'($urandom_range(0, 255));
        c.b = CH_W'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic rgb_t mk_rgb(input int r, input int g, input int b);
        rgb_t c;
        c.r = CH_W'(r);
        c.g = CH_W'(g);
        c.b = CH_W'(b);
        return c;
    endfunction

    task automatic queue_load(input int m, input bit st, input bit rv, input int pos,
                              input rgb_t col);
        cmd_t c;
        c.opcode = OP_LOAD;
        c.map = 2'(m);
        c.start_map = st;
        c.rev = rv;
        c.pos = POS_W'(pos);
        c.rgb = col;
        cmds_to_send.push_back(c);
    endtask

    // unused fields of a query still carry random values
    task automatic queue_query(input int m, input int pos);
        cmd_t c;
        c.opcode = OP_QUERY;
        c.map = 2'(m);
        c.start_map = 1'($urandom_range(0, 1));
        c.rev = 1'($urandom_range(0, 1));
        c.pos = POS_W'(pos);
        c.rgb = rand_rgb();
        cmds_to_send.push_back(c);
    endtask

    task automatic queue_directed();
        // empty map, then a black to white ramp with extreme indices
        queue_query(0, 500);
        queue_load(0, 1, 0, 0, mk_rgb(0, 0, 0));
        queue_load(0, 0, 0, 1000, mk_rgb(255, 255, 255));
        queue_query(0, 0);
        queue_query(0, 500);
        queue_query(0, 999);
        queue_query(0, 1000);
        queue_query(0, 1023);
        // decreasing position is refused, an equal one is taken
        queue_load(0, 0, 0, 999, mk_rgb(1, 1, 1));
        queue_load(0, 0, 0, 1000, mk_rgb(10, 20, 30));
        queue_query(0, 1000);
        // reversed pairing, reverse bit kept by later loads, repeated position
        queue_load(1, 1, 1, 100, mk_rgb(255, 0, 0));
        queue_load(1, 0, 0, 200, mk_rgb(0, 255, 0));
        queue_load(1, 0, 0, 200, mk_rgb(0, 0, 255));
        queue_load(1, 0, 1, 300, mk_rgb(255, 255, 255));
        queue_query(1, 50);
        queue_query(1, 150);
        queue_query(1, 200);
        queue_query(1, 250);
        queue_query(1, 300);
        // single point map at the top of the range
        queue_load(2, 1, 0, 1023, mk_rgb(200, 100, 50));
        queue_query(2, 5);
        queue_query(2, 1023);
        // a start load clears a map whatever its old contents
        queue_load(3, 1, 1, 0, mk_rgb(255, 255, 255));
        queue_load(3, 1, 0, 700, mk_rgb(1, 2, 3));
        queue_query(3, 699);
    endtask

    // mostly well-formed map builds followed by lookups, plus some noise
    task automatic queue_random_maps(input int target);
        int m, n, kind, step, p, lo, nq, sel, i;
        bit first_seq;
        cmd_t c;
        first_seq = 1'b1;
        while (cmds_to_send.size() < target)
        begin
            m = $urandom_range(0, NUM_MAPS - 1);
            kind = $urandom_range(0, 99);
            lo = 0;
            p = 1023;
            if (first_seq || kind < 4)
            begin
                // fill to capacity, then push past it
                p = $urandom_range(0, 40);
                lo = p;
                queue_load(m, 1, 1'($urandom_range(0, 1)), p, rand_rgb());
                for (i = 1; i < MAX_POINTS + 2; i++)
                begin
                    p = p + $urandom_range(0, 15);
                    queue_load(m, 0, 1'($urandom_range(0, 1)), p, rand_rgb());
                end
                nq = 8;
            end
            else if (kind < 72)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                : $urandom_range(1, 8);
                step = 1100 / n + 1;
                p = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 400);
                lo = p;
                queue_load(m, 1, 1'($urandom_range(0, 1)), p, rand_rgb());
                for (i = 1; i < n; i++)
                begin
                    if (p > 0 && $urandom_range(0, 19) == 0)
                        queue_load(m, 0, 1'($urandom_range(0, 1)),
                                   $urandom_range(0, p - 1), rand_rgb());
                    p = p + $urandom_range(0, step);
                    if (p > 1023)
                        p = 1023;
                    queue_load(m, 0, 1'($urandom_range(0, 1)), p, rand_rgb());
                end
                nq = $urandom_range(2, 8);
            end
            else
            begin
                // noise: every field random
                nq = 0;
                for (i = $urandom_range(1, 6); i > 0; i--)
                begin
                    c.opcode = 1'($urandom_range(0, 1));
                    c.map = 2'($urandom_range(0, 3));
                    c.start_map = 1'($urandom_range(0, 1));
                    c.rev = 1'($urandom_range(0, 1));
                    c.pos = POS_W'($urandom_range(0, 1023));
                    c.rgb = rand_rgb();
                    cmds_to_send.push_back(c);
                end
            end
            for (i = 0; i < nq; i++)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    queue_query(m, $urandom_range(lo, p));
                else if (sel < 9)
                    queue_query(m, $urandom_range(0, 1023));
                else
                begin
                    case ($urandom_range(0, 3))
                        0: queue_query(m, 0);
                        1: queue_query(m, 999);
                        2: queue_query(m, 1000);
                        default: queue_query(m, 1023);
                    endcase
                end
            end
            first_seq = 1'b0;
        end
    endtask

    // driver: predict on each accepted transfer, then present the next command
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                lookup_colour(cur_cmd, predicted);
                expected_colours.push_back(predicted);
                sent_count++;
            end
            if (!start || !busy)
            begin
                // random idle cycles, none in a calm window mid-run
                hold_off = !(sent_count >= 600 && sent_count < 900) &&
                           ($urandom_range(0, 99) < 14);
                if (cmds_to_send.size() != 0 && !hold_off)
                begin
                    cur_cmd = cmds_to_send.pop_front();
                    start <= 1'b1;
                    opcode <= cur_cmd.opcode;
                    map_select <= cur_cmd.map;
                    start_map <= cur_cmd.start_map;
                    reverse_order <= cur_cmd.rev;
                    position <= cur_cmd.pos;
                    red_in <= cur_cmd.rgb.r;
                    green_in <= cur_cmd.rgb.g;
                    blue_in <= cur_cmd.rgb.b;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: each strobed result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_colours.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: rgb %02h %02h %02h status %0d",
                             $time, out_red, out_green, out_blue, status);
            end
            else
            begin
                expected_head = expected_colours.pop_front();
                if (out_red !== expected_head.rgb.r || out_green !== expected_head.rgb.g ||
                    out_blue !== expected_head.rgb.b || status !== expected_head.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch: expected rgb %02h %02h %02h status %0d, got rgb %02h %02h %02h status %0d",
                                 $time, expected_head.rgb.r, expected_head.rgb.g,
                                 expected_head.rgb.b, expected_head.status,
                                 out_red, out_green, out_blue, status);
                end
            end
        end
    end

    initial
    begin
        queue_directed();
        queue_random_maps(cmds_to_send.size() + 1800);
        total_cmds = cmds_to_send.size();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (sent_count < total_cmds)
            @(posedge clk);
        while (expected_colours.size() != 0)
            @(posedge clk);
        // settle time covers the slowest lookup
        repeat (200) @(posedge clk);
        $display("covered %0d loads (%0d refused as full, %0d out of order) on %0d maps",
                 n_loads, n_full, n_order, NUM_MAPS);
        $display("and %0d lookups (%0d on empty maps, %0d blended inside a segment)",
                 n_queries, n_empty, n_blend);
        if (mismatches == 0)
            $display("piecewise_linear_colormap regression: pass");
        else
            $display("piecewise_linear_colormap regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #30_000_000;
        $display("piecewise_linear_colormap regression: fail");
        $finish;
    end

endmodule
